FILE: rtl/weighted_majority_expert_select_assert.svh
// assertion macros for the weighted majority expert select checker
// expects signals named clock and reset in the scope where a macro is used
`ifndef WEIGHTED_MAJORITY_EXPERT_SELECT_ASSERT_SVH
`define WEIGHTED_MAJORITY_EXPERT_SELECT_ASSERT_SVH

// property checked at every clock edge outside reset
`define WMES_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("wmes assertion failed");

// property checked at every clock edge, reset included
`define WMES_ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("wmes assertion failed");

`endif

FILE: rtl/wmes_pkg.sv
// shared constants for the weighted majority expert select block
// no dependencies
package wmes_pkg;

   localparam int DEF_MAX_EXPERTS = 64;
   localparam int DEF_WEIGHT_BITS = 32;

   localparam int ALPHA_BITS     = 16;
   localparam int NUSE_BITS      = 7;
   localparam int VOTE_BITS      = 64;
   localparam int FRAC_BITS      = 32;
   localparam int CHOSEN_BITS    = 6;
   localparam int CSR_DATA_BITS  = 16;
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_ALPHA = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NUSE  = 2'd1;

   localparam logic [ALPHA_BITS-1:0] ALPHA_RESET = 16'd32768;
   localparam logic [NUSE_BITS-1:0]  NUSE_RESET  = 7'd64;

endpackage

FILE: rtl/wmes_weight_store.sv
// weight memory: one write and one registered read port per cycle
// per-entry valid bits give the reset weight until an entry is written; uses wmes_pkg
module wmes_weight_store
   import wmes_pkg::*;
#(
   parameter int DEPTH = DEF_MAX_EXPERTS,
   parameter int WIDTH = DEF_WEIGHT_BITS,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data
);

   localparam logic [WIDTH-1:0] WEIGHT_RESET = {1'b1, {(WIDTH-1){1'b0}}};

   logic [WIDTH-1:0] mem [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [WIDTH-1:0] rd_data_ff;
   logic             rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   // never-written entries still hold the reset weight
   assign rd_data = rd_valid_ff ? rd_data_ff : WEIGHT_RESET;

endmodule

FILE: rtl/weighted_majority_expert_select.sv
// Randomized weighted majority expert select, top level.
// Input channel req_*: one item per transfer carrying all expert votes, the true
// label and a Q0.32 random fraction. Result channel rsp_*: one result per item
// with the predicted label, the sampled expert and the mistake flag. Both use
// valid/stall; a transfer happens when valid is high and stall is low.
// Configuration csr_*: write alpha (index 0) or experts in use (index 1) while
// the block is idle; writes take effect at once.
// Steps: for an item with n experts in use, one pass over the weight memory sums
// the weights, states MLO and MHI form two 32x32 partial products and state TGT
// adds them into the scaled target, a second pass samples the expert and writes
// back penalized weights, one memory read and one write per cycle, and state OUT
// loads the result.
// req_stall is high from the transfer until the result is loaded.
// The result sits in an output register; a new item is taken while it waits.
// If rsp_stall holds the previous result, the block waits before loading.
// Reset (synchronous) restores every weight to half scale through
// per-entry valid bits and sets alpha and experts in use to their defaults.
module weighted_majority_expert_select
   import wmes_pkg::*;
#(
   parameter int MAX_EXPERTS = DEF_MAX_EXPERTS,
   parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [VOTE_BITS-1:0]      req_expert_votes,
   input  logic                      req_true_label,
   input  logic [FRAC_BITS-1:0]      req_random_fraction,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_predicted_label,
   output logic [CHOSEN_BITS-1:0]    rsp_picked_expert,
   output logic                      rsp_mistake,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int IDX_BITS  = (MAX_EXPERTS > 1) ? $clog2(MAX_EXPERTS) : 1;
   localparam int CNT_BITS  = $clog2(MAX_EXPERTS + 1);
   localparam int SUM_BITS  = WEIGHT_BITS + IDX_BITS;
   localparam int PROD_BITS = WEIGHT_BITS + ALPHA_BITS;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SUM  = 3'd1;
   localparam logic [2:0] ST_MLO  = 3'd2;
   localparam logic [2:0] ST_MHI  = 3'd3;
   localparam logic [2:0] ST_TGT  = 3'd4;
   localparam logic [2:0] ST_SEL  = 3'd5;
   localparam logic [2:0] ST_OUT  = 3'd6;

   logic [2:0]             state_ff, state_in;
   logic [ALPHA_BITS-1:0]  alpha_ff;
   logic [NUSE_BITS-1:0]   nuse_ff;
   logic [VOTE_BITS-1:0]   votes_ff, votes_in;
   logic                   label_ff, label_in;
   logic [FRAC_BITS-1:0]   frac_ff, frac_in;
   logic [CNT_BITS-1:0]    n_ff, n_in;
   logic [CNT_BITS-1:0]    cnt_ff, cnt_in;
   logic                   rd_vld_ff, rd_vld_in;
   logic [IDX_BITS-1:0]    rd_idx_ff, rd_idx_in;
   logic [SUM_BITS-1:0]    sum_ff, sum_in;
   logic [63:0]            plo_ff, plo_in;
   logic [63:0]            phi_ff, phi_in;
   logic [SUM_BITS-1:0]    target_ff, target_in;
   logic [SUM_BITS-1:0]    run_ff, run_in;
   logic                   found_ff, found_in;
   logic [IDX_BITS-1:0]    chosen_ff, chosen_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_pred_ff, rsp_pred_in;
   logic [CHOSEN_BITS-1:0] rsp_chosen_ff, rsp_chosen_in;
   logic                   rsp_mistake_ff, rsp_mistake_in;

   logic [CNT_BITS-1:0]    nuse_sat;
   logic                   issue;
   logic                   rd_en;
   logic                   wr_en;
   logic [WEIGHT_BITS-1:0] weight;
   logic [PROD_BITS-1:0]   prod;
   logic [SUM_BITS-1:0]    run_next;
   logic [63:0]            sum64;
   logic [63:0]            t64;
   logic                   pred;

   wmes_weight_store #(
      .DEPTH (MAX_EXPERTS),
      .WIDTH (WEIGHT_BITS)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (cnt_ff[IDX_BITS-1:0]),
      .rd_data (weight),
      .wr_en   (wr_en),
      .wr_addr (rd_idx_ff),
      .wr_data (prod[PROD_BITS-1:ALPHA_BITS])
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= ALPHA_RESET;
         nuse_ff  <= NUSE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ALPHA: alpha_ff <= csr_wdata;
            CSR_NUSE:  nuse_ff  <= csr_wdata[NUSE_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (nuse_ff == '0) begin
         nuse_sat = CNT_BITS'(1);
      end else if (nuse_ff > NUSE_BITS'(MAX_EXPERTS)) begin
         nuse_sat = CNT_BITS'(MAX_EXPERTS);
      end else begin
         nuse_sat = nuse_ff[CNT_BITS-1:0];
      end
   end

   assign issue    = (cnt_ff < n_ff);
   assign prod     = PROD_BITS'(weight) * PROD_BITS'(alpha_ff);
   assign run_next = run_ff + SUM_BITS'(weight);
   assign sum64    = 64'(sum_ff);
   assign t64      = phi_ff + 64'(plo_ff[63:32]) + 64'(plo_ff[31:0] != 32'd0);
   assign pred     = votes_ff[CHOSEN_BITS'(chosen_ff)];

   always_comb begin
      state_in       = state_ff;
      votes_in       = votes_ff;
      label_in       = label_ff;
      frac_in        = frac_ff;
      n_in           = n_ff;
      cnt_in         = cnt_ff;
      rd_vld_in      = 1'b0;
      rd_idx_in      = rd_idx_ff;
      sum_in         = sum_ff;
      plo_in         = plo_ff;
      phi_in         = phi_ff;
      target_in      = target_ff;
      run_in         = run_ff;
      found_in       = found_ff;
      chosen_in      = chosen_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_pred_in    = rsp_pred_ff;
      rsp_chosen_in  = rsp_chosen_ff;
      rsp_mistake_in = rsp_mistake_ff;
      rd_en          = 1'b0;
      wr_en          = 1'b0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               votes_in = req_expert_votes;
               label_in = req_true_label;
               frac_in  = req_random_fraction;
               n_in     = nuse_sat;
               cnt_in   = '0;
               sum_in   = '0;
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            if (issue) begin
               rd_en     = 1'b1;
               cnt_in    = cnt_ff + CNT_BITS'(1);
               rd_vld_in = 1'b1;
               rd_idx_in = cnt_ff[IDX_BITS-1:0];
            end
            if (rd_vld_ff) begin
               sum_in = sum_ff + SUM_BITS'(weight);
            end
            if (!issue && !rd_vld_ff) begin
               state_in = ST_MLO;
            end
         end
         ST_MLO: begin
            plo_in   = 64'(frac_ff) * 64'(sum64[31:0]);
            state_in = ST_MHI;
         end
         ST_MHI: begin
            phi_in   = 64'(frac_ff) * 64'(sum64[63:32]);
            state_in = ST_TGT;
         end
         ST_TGT: begin
            // ceil(frac * sum / 2^32)
            target_in = t64[SUM_BITS-1:0];
            cnt_in    = '0;
            run_in    = '0;
            found_in  = 1'b0;
            chosen_in = '0;
            state_in  = ST_SEL;
         end
         ST_SEL: begin
            if (issue) begin
               rd_en     = 1'b1;
               cnt_in    = cnt_ff + CNT_BITS'(1);
               rd_vld_in = 1'b1;
               rd_idx_in = cnt_ff[IDX_BITS-1:0];
            end
            if (rd_vld_ff) begin
               run_in = run_next;
               if (!found_ff && run_next >= target_ff) begin
                  found_in  = 1'b1;
                  chosen_in = rd_idx_ff;
               end
               // penalize the previous entry while the next one is read
               wr_en = (votes_ff[CHOSEN_BITS'(rd_idx_ff)] != label_ff);
            end
            if (!issue && !rd_vld_ff) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               rsp_pred_in    = pred;
               rsp_chosen_in  = CHOSEN_BITS'(chosen_ff);
               rsp_mistake_in = pred ^ label_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      votes_ff       <= votes_in;
      label_ff       <= label_in;
      frac_ff        <= frac_in;
      n_ff           <= n_in;
      cnt_ff         <= cnt_in;
      rd_idx_ff      <= rd_idx_in;
      sum_ff         <= sum_in;
      plo_ff         <= plo_in;
      phi_ff         <= phi_in;
      target_ff      <= target_in;
      run_ff         <= run_in;
      found_ff       <= found_in;
      chosen_ff      <= chosen_in;
      rsp_pred_ff    <= rsp_pred_in;
      rsp_chosen_ff  <= rsp_chosen_in;
      rsp_mistake_ff <= rsp_mistake_in;
   end

   assign req_stall           = (state_ff != ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_predicted_label = rsp_pred_ff;
   assign rsp_picked_expert   = rsp_chosen_ff;
   assign rsp_mistake         = rsp_mistake_ff;

endmodule

FILE: rtl/wmes_checker.sv
// port-level checks for the weighted majority expert select top level
// uses wmes_pkg and the assertion macros; bound to the top level below
`include "weighted_majority_expert_select_assert.svh"

module wmes_checker
   import wmes_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input logic [CHOSEN_BITS-1:0] rsp_picked_expert
);

   // a transfer in starts work, so the block is busy right after it
   `WMES_ASSERT(busy_after_req, req_valid && !req_stall |=> req_stall)

   // a result is only loaded while an item is in progress
   `WMES_ASSERT(rsp_from_work, $rose(rsp_valid) |-> $past(req_stall))

   // reset leaves the block idle with no result pending
   `WMES_ASSERT_ALWAYS(idle_after_reset, reset |=> !req_stall && !rsp_valid)

   // a stalled result holds
   `WMES_ASSERT(rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_picked_expert))

endmodule

bind weighted_majority_expert_select wmes_checker u_wmes_checker (.*);
